[rtl/w3if_pkg.sv]
// ----------------------------------------------------------------------------
// w3if_pkg
// Types and codes shared by the 3x3 window image filter.
// ----------------------------------------------------------------------------
package w3if_pkg;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GREY     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd3;

  localparam logic [1:0] MODE_SMOOTH  = 2'd0;
  localparam logic [1:0] MODE_EDGE    = 2'd1;
  localparam logic [1:0] MODE_SHARPEN = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // floor(x / 9) == (x * DIV9_MUL) >> DIV9_SHIFT for x below 4096
  localparam logic [11:0] DIV9_MUL   = 12'd3641;
  localparam int          DIV9_SHIFT = 15;

  typedef struct packed {
    logic             opcode;
    logic [PIX_W-1:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] filtered_pixel;
    logic             last_of_frame;
    logic             dropped;
  } out_word_t;

endpackage

[rtl/window3x3_image_filter_top.sv]
// ----------------------------------------------------------------------------
// window3x3_image_filter_top
// Streaming 3x3 smooth / edge / sharpen filter with two line stores.
// ----------------------------------------------------------------------------
// One word is accepted per clock cycle with no bubbles unless out_stall backs
// up into the stage register. A pixel word reads both line stores at its column
// in the accept cycle; when its stage moves on, the window shifts, the line
// stores are written back and the filtered result is registered for output. The output
// register lets one more word enter while a result waits on out_stall. The
// line stores need no clearing after reset. Drain words flush the width+1
// border zeros that follow the last pixel of a frame.
module window3x3_image_filter_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  w3if_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output w3if_pkg::out_word_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [w3if_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [w3if_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WBITS = $clog2(MAX_WIDTH + 2);
  localparam int HBITS = $clog2(MAX_HEIGHT);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int SWW   = (WBITS > w3if_pkg::CFG_DATA_W) ? WBITS : w3if_pkg::CFG_DATA_W;
  localparam int SHW   = (HW > w3if_pkg::CFG_DATA_W) ? HW : w3if_pkg::CFG_DATA_W;

  typedef struct packed {
    logic          has;
    logic          pix;
    logic          border;
    logic          last;
    logic          drop;
    logic [7:0]    px;
    logic [AW-1:0] col;
  } s1_word_t;

  // configuration
  logic [w3if_pkg::CFG_DATA_W-1:0] frame_width_r, frame_height_r;
  logic [7:0]                      max_grey_r;
  logic [1:0]                      filter_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 11'd1024;
      frame_height_r <= 11'd1024;
      max_grey_r     <= 8'd255;
      filter_mode_r  <= w3if_pkg::MODE_SMOOTH;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        w3if_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        w3if_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        w3if_pkg::REG_MAX_GREY:     max_grey_r     <= cfg_data[7:0];
        w3if_pkg::REG_FILTER_MODE:  filter_mode_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [SWW-1:0]   w_ext, w_sat;
  logic [SHW-1:0]   h_ext, h_sat;
  logic [WBITS-1:0] w;
  logic [HW-1:0]    h;

  always_comb begin
    w_ext = SWW'(frame_width_r);
    h_ext = SHW'(frame_height_r);
    if (w_ext < SWW'(3))              w_sat = SWW'(3);
    else if (w_ext > SWW'(MAX_WIDTH)) w_sat = SWW'(MAX_WIDTH);
    else                              w_sat = w_ext;
    if (h_ext < SHW'(3))               h_sat = SHW'(3);
    else if (h_ext > SHW'(MAX_HEIGHT)) h_sat = SHW'(MAX_HEIGHT);
    else                               h_sat = h_ext;
    w = w_sat[WBITS-1:0];
    h = h_sat[HW-1:0];
  end

  // handshake and pipeline control
  logic             s1_v_r, s1_go, out_valid_r, in_accept, s1_load;
  s1_word_t         s1_r, s1_nxt;
  logic [AW-1:0]    col_r, col_nxt;
  logic [HBITS-1:0] row_r, row_nxt;
  logic [WBITS-1:0] pend_r, pend_nxt;
  w3if_pkg::out_word_t out_data_r, res_word;

  assign s1_go     = s1_v_r && !(s1_r.has && out_valid_r && out_stall);
  assign in_stall  = s1_v_r && !s1_go;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic col_end, row_end, have;

  always_comb begin
    col_end  = (WBITS'(col_r) + WBITS'(1)) >= w;
    row_end  = (HW'(row_r) + HW'(1)) >= h;
    have     = (row_r >= HBITS'(2)) || ((row_r == HBITS'(1)) && (col_r != '0));
    col_nxt  = col_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    s1_load  = 1'b0;
    s1_nxt        = '0;
    s1_nxt.px     = in_data.pixel_value;
    s1_nxt.col    = col_r;
    s1_nxt.border = (col_r == AW'(0)) || (col_r == AW'(1)) || (row_r == HBITS'(1)) ||
                    (HW'(row_r) >= h) || (WBITS'(col_r) >= w);
    if (in_data.opcode == w3if_pkg::OP_DRAIN) begin
      if (pend_r != '0) begin
        s1_load     = 1'b1;
        s1_nxt.has  = 1'b1;
        s1_nxt.last = (pend_r == WBITS'(1));
        pend_nxt    = pend_r - WBITS'(1);
      end
    end else if (pend_r != '0) begin
      s1_load     = 1'b1;
      s1_nxt.has  = 1'b1;
      s1_nxt.drop = 1'b1;
    end else begin
      s1_load    = 1'b1;
      s1_nxt.pix = 1'b1;
      s1_nxt.has = have;
      if (col_end) begin
        col_nxt = '0;
        if (row_end) begin
          row_nxt  = '0;
          pend_nxt = w + WBITS'(1);
        end else begin
          row_nxt = row_r + HBITS'(1);
        end
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      pend_r      <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        pend_r <= pend_nxt;
        s1_v_r <= s1_load;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go && s1_r.has)           out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) s1_r <= s1_nxt;
    if (s1_go && s1_r.has) out_data_r <= res_word;
  end

  // line stores
  logic [7:0] upper_mem [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];
  logic [7:0] top_rd_r, mid_rd_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      top_rd_r <= upper_mem[col_r];
      mid_rd_r <= middle_mem[col_r];
    end
    if (s1_go && s1_r.pix) begin
      upper_mem[s1_r.col]  <= mid_rd_r;
      middle_mem[s1_r.col] <= s1_r.px;
    end
  end

  // window
  logic [7:0] win_r [9];
  logic [7:0] win_nxt [9];

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top_rd_r;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_rd_r;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_r.px;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else if (s1_go && s1_r.pix) begin
      for (int i = 0; i < 9; i++) win_r[i] <= win_nxt[i];
    end
  end

  // filter arithmetic
  logic [11:0]        sum_all, dividend, ctr10;
  logic [9:0]         pos4, neg4, adiff;
  logic [23:0]        prod;
  logic signed [13:0] sharp;
  logic [7:0]         fval;

  always_comb begin
    sum_all = ((12'(win_nxt[0]) + 12'(win_nxt[1])) + (12'(win_nxt[2]) + 12'(win_nxt[3]))) +
              ((12'(win_nxt[4]) + 12'(win_nxt[5])) + (12'(win_nxt[6]) + 12'(win_nxt[7]))) +
              12'(win_nxt[8]);
    pos4  = {win_nxt[4], 2'b00};
    neg4  = (10'(win_nxt[1]) + 10'(win_nxt[3])) + (10'(win_nxt[5]) + 10'(win_nxt[7]));
    adiff = (pos4 >= neg4) ? (pos4 - neg4) : (neg4 - pos4);
    dividend = (filter_mode_r == w3if_pkg::MODE_SMOOTH) ? sum_all : 12'(adiff);
    prod  = 24'(dividend) * 24'(w3if_pkg::DIV9_MUL);
    ctr10 = {1'b0, win_nxt[4], 3'b000} + {3'b000, win_nxt[4], 1'b0};
    sharp = $signed({2'b00, ctr10}) - $signed({2'b00, sum_all});
    case (filter_mode_r)
      w3if_pkg::MODE_SMOOTH,
      w3if_pkg::MODE_EDGE: fval = prod[w3if_pkg::DIV9_SHIFT +: 8];
      w3if_pkg::MODE_SHARPEN: begin
        if (sharp < 14'sd0)                            fval = 8'd0;
        else if (sharp > $signed({6'd0, max_grey_r})) fval = max_grey_r;
        else                                           fval = sharp[7:0];
      end
      default: fval = 8'd0;
    endcase
    res_word.filtered_pixel = (s1_r.pix && !s1_r.border) ? fval : 8'd0;
    res_word.last_of_frame  = s1_r.last;
    res_word.dropped        = s1_r.drop;
  end

  // checks
  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && s1_r.has))
    else $error("input stalled while output register free");

  a_no_store_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && pend_r != '0) |=> !(s1_v_r && s1_r.pix))
    else $error("pixel stored while drains pending");

  a_last_is_drain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last_of_frame) |->
      (out_data_r.filtered_pixel == 8'd0 && !out_data_r.dropped))
    else $error("last_of_frame word not a clean drain zero");

  a_result_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_r.has) |=> out_valid_r)
    else $error("result lost between stages");

endmodule

[sim/window3x3_image_filter_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window3x3_image_filter_top_tb
// Self-checking bench for the 3x3 window image filter. A queue-fed driver
// pushes pixel and drain words with random gaps, a monitor applies random
// back-pressure and checks every output word against a line-store predictor
// kept in step at each accepted input word. Frame geometry, clamp and mode
// are rewritten between frames and in mid frame, the geometry there by narrowing only.
// ----------------------------------------------------------------------------
module window3x3_image_filter_top_tb;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;
  localparam int WORD_TARGET   = 1650;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  w3if_pkg::in_word_t   in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  w3if_pkg::out_word_t  out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [w3if_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [w3if_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  window3x3_image_filter_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor state
  bit [7:0]  upper_line [MAX_W];
  bit [7:0]  middle_line [MAX_W];
  bit [7:0]  win [9];
  int        col_pos = 0;
  int        row_pos = 0;
  int        drains_left = 0;
  bit [10:0] cfg_width = 11'd1024;
  bit [10:0] cfg_height = 11'd1024;
  bit [7:0]  cfg_grey = 8'd255;
  bit [1:0]  cfg_mode = w3if_pkg::MODE_SMOOTH;

  w3if_pkg::in_word_t  pending_words [$];
  w3if_pkg::out_word_t expected_pixels [$];
  int        mismatch_count = 0;
  int        stim_words = 0;
  int        drive_burst = 0;
  int        stall_burst = 0;
  int        idle_left = 0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  function automatic int clamp_dim(logic [10:0] v, int hi);
    if (int'(v) < 3) return 3;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int draw_wait(inout int burst);
    int n;
    n = 0;
    if (burst > 0) begin
      burst--;
    end else if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(8, 40);
    end else begin
      n = $urandom_range(0, 14);
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic advance_filter(input w3if_pkg::in_word_t word, output bit has_out,
                                output w3if_pkg::out_word_t res);
    int w, h, c, r, idx, top, midv, sum, centre, pos, neg, val, orow, ocol, k;
    has_out = 1'b0;
    res = '0;
    w = clamp_dim(cfg_width, MAX_W);
    h = clamp_dim(cfg_height, MAX_H);
    c = col_pos;
    r = row_pos;
    if (word.opcode == w3if_pkg::OP_DRAIN) begin
      if (drains_left != 0) begin
        drains_left--;
        has_out = 1'b1;
        res.last_of_frame = (drains_left == 0);
      end
    end else if (drains_left != 0) begin
      has_out = 1'b1;
      res.dropped = 1'b1;
    end else begin
      idx = (c < MAX_W) ? c : MAX_W - 1;
      top = int'(upper_line[idx]);
      midv = int'(middle_line[idx]);
      upper_line[idx] = midv[7:0];
      middle_line[idx] = word.pixel_value;
      win[0] = win[1]; win[1] = win[2]; win[2] = top[7:0];
      win[3] = win[4]; win[4] = win[5]; win[5] = midv[7:0];
      win[6] = win[7]; win[7] = win[8]; win[8] = word.pixel_value;
      if (r >= 2 || (r == 1 && c >= 1)) begin
        has_out = 1'b1;
        if (c >= 1) begin
          orow = r - 1;
          ocol = c - 1;
        end else begin
          orow = r - 2;
          ocol = w - 1;
        end
        if (!(orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1)) begin
          sum = 0;
          for (k = 0; k < 9; k++) sum += int'(win[k]);
          centre = int'(win[4]);
          case (cfg_mode)
            w3if_pkg::MODE_SMOOTH: val = sum / 9;
            w3if_pkg::MODE_EDGE: begin
              pos = 4 * centre;
              neg = int'(win[1]) + int'(win[3]) + int'(win[5]) + int'(win[7]);
              val = (pos >= neg) ? (pos - neg) / 9 : (neg - pos) / 9;
            end
            w3if_pkg::MODE_SHARPEN: begin
              val = 9 * centre - (sum - centre);
              if (val < 0) val = 0;
              if (val > int'(cfg_grey)) val = int'(cfg_grey);
            end
            default: val = 0;
          endcase
          res.filtered_pixel = val[7:0];
        end
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        if (r + 1 >= h) begin
          row_pos = 0;
          drains_left = w + 1;
        end else begin
          row_pos = r + 1;
        end
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    bit                  got;
    w3if_pkg::out_word_t res;
    int                  g;
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else if (in_valid && !in_stall) begin
      advance_filter(in_data, got, res);
      if (got) expected_pixels.push_back(res);
      g = draw_wait(drive_burst);
      if (g == 0 && pending_words.size() != 0) begin
        in_data <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
        idle_left = g;
      end
    end else if (!in_valid) begin
      if (idle_left > 0) begin
        idle_left--;
      end else if (pending_words.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    w3if_pkg::out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected word", int'(out_data.filtered_pixel), 0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.filtered_pixel !== want.filtered_pixel)
          report_mismatch("filtered_pixel", int'(out_data.filtered_pixel),
                          int'(want.filtered_pixel));
        if (out_data.last_of_frame !== want.last_of_frame)
          report_mismatch("last_of_frame", int'(out_data.last_of_frame),
                          int'(want.last_of_frame));
        if (out_data.dropped !== want.dropped)
          report_mismatch("dropped", int'(out_data.dropped), int'(want.dropped));
      end
      hold_left = draw_wait(stall_burst);
      out_stall <= (hold_left != 0);
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= (hold_left != 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic queue_word(input logic op, input logic [7:0] px);
    w3if_pkg::in_word_t wd;
    wd.opcode = op;
    wd.pixel_value = px;
    pending_words.push_back(wd);
  endtask

  task automatic queue_frame_pixels(input int n, input int style, input bit noisy,
                                    input bit counted);
    int       i;
    logic [7:0] level, px;
    level = 8'($urandom_range(0, 240));
    for (i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 39) == 0)
        queue_word(w3if_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
      case (style)
        0: px = 8'($urandom_range(0, 255));
        1: px = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        2: px = level + 8'($urandom_range(0, 15));
        default: px = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
      endcase
      queue_word(w3if_pkg::OP_PIXEL, px);
      if (counted) stim_words++;
    end
  endtask

  // drains with the odd dropped pixel mixed in, sometimes a few spare drains
  task automatic queue_drains(input int n, input bit counted);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        queue_word(w3if_pkg::OP_PIXEL, 8'($urandom_range(0, 255)));
        if (counted) stim_words++;
      end
      queue_word(w3if_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
      if (counted) stim_words++;
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) queue_word(w3if_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
  endtask

  // valid only while idle
  function automatic int pixels_to_frame_end();
    int c, r, w, h, n;
    c = col_pos;
    r = row_pos;
    w = clamp_dim(cfg_width, MAX_W);
    h = clamp_dim(cfg_height, MAX_H);
    n = 0;
    while (1'b1) begin
      n++;
      if (c + 1 >= w) begin
        if (r + 1 >= h) break;
        c = 0;
        r++;
      end else begin
        c++;
      end
    end
    return n;
  endfunction

  function automatic logic [10:0] pick_grey_word();
    logic [10:0] v;
    v = 11'($urandom_range(0, 2047));
    case ($urandom_range(0, 5))
      0: v[7:0] = 8'd0;
      1: v[7:0] = 8'd1;
      2: v[7:0] = 8'd255;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [10:0] pick_mode_word();
    logic [10:0] v;
    v = 11'($urandom_range(0, 2047));
    v[1:0] = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    return v;
  endfunction

  // call at a clock edge; leaves the write enable low
  task automatic apply_settings(input logic [3:0] sel, input logic [10:0] w, h, g, m);
    logic [10:0] vals [4];
    int i;
    vals = '{w, h, g, m};
    for (i = 0; i < 4; i++) begin
      if (sel[i]) begin
        cfg_wr_en <= 1'b1;
        cfg_index <= i[w3if_pkg::CFG_IDX_W-1:0];
        cfg_data <= vals[i];
        case (i[w3if_pkg::CFG_IDX_W-1:0])
          w3if_pkg::REG_FRAME_WIDTH:  cfg_width = vals[i];
          w3if_pkg::REG_FRAME_HEIGHT: cfg_height = vals[i];
          w3if_pkg::REG_MAX_GREY:     cfg_grey = vals[i][7:0];
          default:                    cfg_mode = vals[i][1:0];
        endcase
        @(posedge clk);
      end
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int i, n, m, phase, style;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // smallest frame, sharpen clamped by max_grey
    apply_settings(4'hF, 11'd3, 11'd3, 11'd200, 11'(w3if_pkg::MODE_SHARPEN));
    queue_word(w3if_pkg::OP_DRAIN, 8'h5A);
    for (i = 0; i < 9; i++) queue_word(w3if_pkg::OP_PIXEL, (i == 4) ? 8'hFF : 8'h00);
    queue_word(w3if_pkg::OP_DRAIN, 8'h00);
    queue_word(w3if_pkg::OP_DRAIN, 8'hFF);
    queue_word(w3if_pkg::OP_PIXEL, 8'hFF);
    queue_word(w3if_pkg::OP_DRAIN, 8'h00);
    queue_word(w3if_pkg::OP_DRAIN, 8'h00);
    queue_word(w3if_pkg::OP_DRAIN, 8'hFF);
    wait_idle();

    // dark centre on white, edge magnitude at its largest
    apply_settings(4'b1000, 11'd0, 11'd0, 11'd0, 11'(w3if_pkg::MODE_EDGE));
    for (i = 0; i < 9; i++) queue_word(w3if_pkg::OP_PIXEL, (i == 4) ? 8'h00 : 8'hFF);
    for (i = 0; i < 4; i++) queue_word(w3if_pkg::OP_DRAIN, 8'h00);
    wait_idle();

    phase = 0;
    while (stim_words < WORD_TARGET) begin
      if (phase == 2 || phase == 6) begin
        // out-of-range size saturates, then the frame is cut short in mid frame
        apply_settings(4'hF, (phase == 2) ? 11'd2047 : 11'd3,
                       (phase == 2) ? 11'd3 : 11'd2047, pick_grey_word(),
                       11'($urandom_range(0, 2)));
        queue_frame_pixels($urandom_range(24, 90), 0, 1'b0, 1'b1);
        wait_idle();
        if (phase == 2)
          apply_settings(4'b0001, 11'($urandom_range(0, 14)), 11'd0, 11'd0, 11'd0);
        else
          apply_settings(4'b0010, 11'd0, 11'($urandom_range(0, 8)), 11'd0, 11'd0);
        queue_frame_pixels(pixels_to_frame_end(), 0, 1'b0, 1'b1);
        queue_drains(clamp_dim(cfg_width, MAX_W) + 1, 1'b1);
      end else begin
        apply_settings(4'hF, 11'($urandom_range(0, 14)), 11'($urandom_range(0, 8)),
                       pick_grey_word(), pick_mode_word());
        style = $urandom_range(0, 3);
        n = pixels_to_frame_end();
        if ($urandom_range(0, 3) == 0) begin
          m = $urandom_range(1, n - 1);
          queue_frame_pixels(m, style, 1'b1, 1'b1);
          wait_idle();
          case ($urandom_range(0, 3))
            0: apply_settings(4'b1000, 11'd0, 11'd0, 11'd0, pick_mode_word());
            1: apply_settings(4'b0100, 11'd0, 11'd0, pick_grey_word(), 11'd0);
            2: apply_settings(4'b0001,
                              11'($urandom_range(0, clamp_dim(cfg_width, MAX_W))),
                              11'd0, 11'd0, 11'd0);
            default: apply_settings(4'b0010, 11'd0,
                                    11'($urandom_range(0, clamp_dim(cfg_height, MAX_H))),
                                    11'd0, 11'd0);
          endcase
          n = pixels_to_frame_end();
        end
        queue_frame_pixels(n, style, 1'b1, 1'b1);
        queue_drains(clamp_dim(cfg_width, MAX_W) + 1, 1'b1);
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[window3x3_image_filter_top.f]
rtl/w3if_pkg.sv
rtl/window3x3_image_filter_top.sv
sim/window3x3_image_filter_top_tb.sv
